### hdl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: point to triangle distance, shared types and constants
// widths of the geometry datapath, weight constant and divider latency
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    // coordinate and dot product widths
    localparam int CW  = 16;          // Q8.8 coordinate
    localparam int DVW = CW + 1;      // base minus point
    localparam int DTW = 34;          // dot products a..e
    localparam int PW  = 68;          // det, sn, tn and divider operands

    // Q1.16 weights
    localparam int QW = 17;
    localparam logic [QW-1:0] W_ONE = 17'd65536;

    // divider: setup, one quotient bit per stage, rounding
    localparam int DIV_LAT = QW + 2;

    localparam int DIST_W = 40;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [DVW-1:0] t_diff;
    typedef logic signed [DTW-1:0] t_dot;
    typedef logic signed [PW-1:0]  t_wide;

    // how the two weights are formed from the two quotients
    typedef enum logic [1:0] {
        MODE_SEP,
        MODE_T_REST,
        MODE_S_REST
    } t_mode;

endpackage

`default_nettype wire

### hdl/point_triangle_distance_core.sv
// ----------------------------------------------------------------------------
// point_triangle_distance_core: squared distance from a point to a triangle
// dot products, region select, two pipelined dividers, residual and square
// ----------------------------------------------------------------------------
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+------------------------
//  query in  | start, busy, i_point_*, i_base_*,       | start high, busy low
//            | i_edge0_*, i_edge1_*                    |
//  result out| o_valid, o_sq_distance, o_weight_s/_t   | o_valid for one cycle
//
//  one item accepted every cycle, busy is never raised
//  result path: 5 dot product and determinant stages, 1 region select,
//  19 in the quotient pipeline (setup, one bit per stage, rounding),
//  5 residual and square stages
//  synchronous reset clears the valid bits only; items in flight are dropped
//  the receiver cannot stall, so nothing holds inside the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module point_triangle_distance_core
    import ptd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [CW-1:0] i_point_x,
    input  wire logic signed [CW-1:0] i_point_y,
    input  wire logic signed [CW-1:0] i_point_z,
    input  wire logic signed [CW-1:0] i_base_x,
    input  wire logic signed [CW-1:0] i_base_y,
    input  wire logic signed [CW-1:0] i_base_z,
    input  wire logic signed [CW-1:0] i_edge0_x,
    input  wire logic signed [CW-1:0] i_edge0_y,
    input  wire logic signed [CW-1:0] i_edge0_z,
    input  wire logic signed [CW-1:0] i_edge1_x,
    input  wire logic signed [CW-1:0] i_edge1_y,
    input  wire logic signed [CW-1:0] i_edge1_z,
    output logic                      o_valid,
    output logic [DIST_W-1:0]         o_sq_distance,
    output logic [QW-1:0]             o_weight_s,
    output logic [QW-1:0]             o_weight_t
);

    localparam int NSTG    = 11 + DIV_LAT;
    localparam int GEO_LEN = 8 + DIV_LAT;
    localparam int SEL_STG = 5;
    localparam int WGT_STG = SEL_STG + DIV_LAT + 1;

    logic       w_accept;
    logic [NSTG-1:0] r_vld;

    t_coord w_pnt [3];
    t_coord w_bse [3];
    t_coord w_e0  [3];
    t_coord w_e1  [3];

    // geometry travelling alongside the datapath
    t_diff  r_dv [GEO_LEN][3];
    t_coord r_e0 [GEO_LEN][3];
    t_coord r_e1 [GEO_LEN][3];

    logic signed [2*CW-1:0] r_aa [3];
    logic signed [2*CW-1:0] r_bb [3];
    logic signed [2*CW-1:0] r_cc [3];
    logic signed [2*CW:0]   r_dd [3];
    logic signed [2*CW:0]   r_ee [3];

    t_dot r_a [3];
    t_dot r_b [3];
    t_dot r_c [3];
    t_dot r_d [3];
    t_dot r_e [3];

    t_wide r_ac, r_bsq, r_be, r_cd, r_bd, r_ae;
    t_wide r_det, r_sn, r_tn;

    logic signed [PW:0] w_x;
    logic signed [35:0] w_ceb, w_adb, w_den, w_ce, w_ad;
    t_wide n_ns, n_ms, n_nt, n_mt;
    t_mode n_mode;
    t_wide r_ns, r_ms, r_nt, r_mt;
    t_mode r_mode [DIV_LAT+1];

    logic [QW-1:0] w_qs, w_qt;
    logic [QW-1:0] n_ws, n_wt;
    logic [QW-1:0] r_wsd [NSTG-WGT_STG];
    logic [QW-1:0] r_wtd [NSTG-WGT_STG];

    logic signed [QW+CW:0] r_ps [3];
    logic signed [QW+CW:0] r_pt [3];
    logic signed [35:0]    w_r   [3];
    logic [35:0]           w_mag [3];
    logic [35:0]           w_rnd [3];
    logic [30:0]           r_m   [3];
    logic [61:0]           r_sq  [3];
    logic [64:0]           w_acc;
    logic [40:0]           w_dist;
    logic [DIST_W-1:0]     r_dist;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_pnt = '{i_point_x, i_point_y, i_point_z};
    assign w_bse = '{i_base_x, i_base_y, i_base_z};
    assign w_e0  = '{i_edge0_x, i_edge0_y, i_edge0_z};
    assign w_e1  = '{i_edge1_x, i_edge1_y, i_edge1_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    // geometry line, dot products, determinant and numerators sn, tn
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dv[0][k] <= t_diff'(w_bse[k]) - t_diff'(w_pnt[k]);
            r_e0[0][k] <= w_e0[k];
            r_e1[0][k] <= w_e1[k];
        end
        for (int j = 1; j < GEO_LEN; j++) begin
            r_dv[j] <= r_dv[j-1];
            r_e0[j] <= r_e0[j-1];
            r_e1[j] <= r_e1[j-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_aa[k] <= r_e0[0][k] * r_e0[0][k];
            r_bb[k] <= r_e0[0][k] * r_e1[0][k];
            r_cc[k] <= r_e1[0][k] * r_e1[0][k];
            r_dd[k] <= r_e0[0][k] * r_dv[0][k];
            r_ee[k] <= r_e1[0][k] * r_dv[0][k];
        end
        r_a[0] <= t_dot'(r_aa[0]) + t_dot'(r_aa[1]) + t_dot'(r_aa[2]);
        r_b[0] <= t_dot'(r_bb[0]) + t_dot'(r_bb[1]) + t_dot'(r_bb[2]);
        r_c[0] <= t_dot'(r_cc[0]) + t_dot'(r_cc[1]) + t_dot'(r_cc[2]);
        r_d[0] <= t_dot'(r_dd[0]) + t_dot'(r_dd[1]) + t_dot'(r_dd[2]);
        r_e[0] <= t_dot'(r_ee[0]) + t_dot'(r_ee[1]) + t_dot'(r_ee[2]);
        for (int j = 1; j < 3; j++) begin
            r_a[j] <= r_a[j-1];
            r_b[j] <= r_b[j-1];
            r_c[j] <= r_c[j-1];
            r_d[j] <= r_d[j-1];
            r_e[j] <= r_e[j-1];
        end
        r_ac  <= r_a[0] * r_c[0];
        r_bsq <= r_b[0] * r_b[0];
        r_be  <= r_b[0] * r_e[0];
        r_cd  <= r_c[0] * r_d[0];
        r_bd  <= r_b[0] * r_d[0];
        r_ae  <= r_a[0] * r_e[0];
        r_det <= r_ac - r_bsq;
        r_sn  <= r_be - r_cd;
        r_tn  <= r_bd - r_ae;
    end

    // region select: operands of the two quotients
    always_comb begin
        w_x   = (PW+1)'(r_sn) + (PW+1)'(r_tn) - (PW+1)'(r_det);
        w_ce  = 36'(r_c[2]) + 36'(r_e[2]);
        w_ad  = 36'(r_a[2]) + 36'(r_d[2]);
        w_ceb = w_ce - 36'(r_b[2]) - 36'(r_d[2]);
        w_adb = w_ad - 36'(r_b[2]) - 36'(r_e[2]);
        w_den = 36'(r_a[2]) - (36'(r_b[2]) <<< 1) + 36'(r_c[2]);
        // zero is 0 over 1, one is 1 over 0
        n_ns   = '0;
        n_ms   = PW'(1);
        n_nt   = '0;
        n_mt   = PW'(1);
        n_mode = MODE_SEP;
        if (w_x[PW] || (w_x == '0)) begin
            if (r_sn[PW-1]) begin
                if (r_tn[PW-1] && r_d[2][DTW-1]) begin
                    n_ns = -t_wide'(r_d[2]);
                    n_ms = t_wide'(r_a[2]);
                end else begin
                    n_nt = -t_wide'(r_e[2]);
                    n_mt = t_wide'(r_c[2]);
                end
            end else if (r_tn[PW-1]) begin
                n_ns = -t_wide'(r_d[2]);
                n_ms = t_wide'(r_a[2]);
            end else begin
                n_ns = r_sn;
                n_ms = r_det;
                n_nt = r_tn;
                n_mt = r_det;
            end
        end else begin
            if (r_sn[PW-1]) begin
                if (!w_ceb[35] && (w_ceb != '0)) begin
                    n_ns   = t_wide'(w_ceb);
                    n_ms   = t_wide'(w_den);
                    n_mode = MODE_T_REST;
                end else if (w_ce[35] || (w_ce == '0)) begin
                    n_nt = PW'(1);
                    n_mt = '0;
                end else begin
                    n_nt = -t_wide'(r_e[2]);
                    n_mt = t_wide'(r_c[2]);
                end
            end else if (r_tn[PW-1]) begin
                if (!w_adb[35] && (w_adb != '0)) begin
                    n_nt   = t_wide'(w_adb);
                    n_mt   = t_wide'(w_den);
                    n_mode = MODE_S_REST;
                end else if (w_ad[35] || (w_ad == '0)) begin
                    n_ns = PW'(1);
                    n_ms = '0;
                end else begin
                    n_ns = -t_wide'(r_d[2]);
                    n_ms = t_wide'(r_a[2]);
                end
            end else begin
                n_ns   = t_wide'(w_ceb);
                n_ms   = t_wide'(w_den);
                n_mode = MODE_T_REST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns <= n_ns;
        r_ms <= n_ms;
        r_nt <= n_nt;
        r_mt <= n_mt;
        r_mode[0] <= n_mode;
        for (int j = 1; j <= DIV_LAT; j++) begin
            r_mode[j] <= r_mode[j-1];
        end
    end

    ptd_div u_div_s (
        .i_clk (i_clk),
        .i_num (r_ns),
        .i_den (r_ms),
        .o_quo (w_qs)
    );

    ptd_div u_div_t (
        .i_clk (i_clk),
        .i_num (r_nt),
        .i_den (r_mt),
        .o_quo (w_qt)
    );

    always_comb begin
        n_ws = w_qs;
        n_wt = w_qt;
        case (r_mode[DIV_LAT])
            MODE_T_REST: begin
                n_wt = W_ONE - w_qs;
            end
            MODE_S_REST: begin
                n_ws = W_ONE - w_qt;
            end
            default: begin
                n_ws = w_qs;
                n_wt = w_qt;
            end
        endcase
    end

    // residual D + s*e0 + t*e1 per axis, rounded to Q.20 and squared
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_r[k]   = 36'($signed({r_dv[GEO_LEN-1][k], 16'b0}))
                     + 36'(r_ps[k]) + 36'(r_pt[k]);
            w_mag[k] = w_r[k][35] ? 36'(-w_r[k]) : 36'(w_r[k]);
            w_rnd[k] = w_mag[k] + 36'd8;
        end
        w_acc  = 65'(r_sq[0]) + 65'(r_sq[1]) + 65'(r_sq[2]) + (65'(1) << 23);
        w_dist = w_acc[64:24];
    end

    always_ff @(posedge i_clk) begin
        r_wsd[0] <= n_ws;
        r_wtd[0] <= n_wt;
        for (int j = 1; j < NSTG - WGT_STG; j++) begin
            r_wsd[j] <= r_wsd[j-1];
            r_wtd[j] <= r_wtd[j-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_ps[k] <= $signed({1'b0, r_wsd[0]}) * r_e0[GEO_LEN-2][k];
            r_pt[k] <= $signed({1'b0, r_wtd[0]}) * r_e1[GEO_LEN-2][k];
            r_m[k]  <= w_rnd[k][34:4];
            r_sq[k] <= r_m[k] * r_m[k];
        end
        r_dist <= w_dist[40] ? '1 : w_dist[DIST_W-1:0];
    end

    assign o_valid       = r_vld[NSTG-1];
    assign o_sq_distance = r_dist;
    assign o_weight_s    = r_wsd[NSTG-WGT_STG-1];
    assign o_weight_t    = r_wtd[NSTG-WGT_STG-1];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##NSTG o_valid)
        else $error("result strobe missing after fixed latency");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weight_s <= W_ONE) && (o_weight_t <= W_ONE))
        else $error("weight above one");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((18'(o_weight_s) + 18'(o_weight_t)) <= (18'(W_ONE) + 18'd1)))
        else $error("weights sum beyond one");

    a_rest_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[WGT_STG-1] && (r_mode[DIV_LAT] == MODE_T_REST))
        |=> ((18'(r_wsd[0]) + 18'(r_wtd[0])) == 18'(W_ONE)))
        else $error("edge weights do not sum to one");
`endif

endmodule

`default_nettype wire

### hdl/ptd_div.sv
// ----------------------------------------------------------------------------
// ptd_div: pipelined Q1.16 quotient
// q(n, m) = 0 for n <= 0, one for m <= n, else round-half-up n*65536/m;
// one restoring step per stage, with setup and rounding stages as counted in DIV_LAT
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_div
    import ptd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic signed [PW-1:0] i_num,
    input  wire logic signed [PW-1:0] i_den,
    output logic [QW-1:0]          o_quo
);

    logic [PW-2:0] r_rem [QW+1];
    logic [PW-2:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [PW-2:0] n_rem [QW+1];
    logic [PW-2:0] n_den [QW+1];
    logic [QW-1:0] n_q   [QW+1];
    logic [QW-1:0] r_quo;
    logic [QW:0]   w_sum;

    always_comb begin
        logic [PW-1:0] v_shl;
        v_shl = '0;
        // trivial cases become operands the steps map to zero or to one
        n_q[0] = '0;
        if (i_num[PW-1] || (i_num == '0)) begin
            n_rem[0] = '0;
            n_den[0] = (PW-1)'(1);
        end else if (i_den <= i_num) begin
            n_rem[0] = '0;
            n_den[0] = '0;
        end else begin
            n_rem[0] = i_num[PW-2:0];
            n_den[0] = i_den[PW-2:0];
        end
        for (int j = 1; j <= QW; j++) begin
            v_shl    = {r_rem[j-1], 1'b0};
            n_den[j] = r_den[j-1];
            if (v_shl >= {1'b0, r_den[j-1]}) begin
                n_rem[j] = (PW-1)'(v_shl - {1'b0, r_den[j-1]});
                n_q[j]   = {r_q[j-1][QW-2:0], 1'b1};
            end else begin
                n_rem[j] = v_shl[PW-2:0];
                n_q[j]   = {r_q[j-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= QW; j++) begin
            r_rem[j] <= n_rem[j];
            r_den[j] <= n_den[j];
            r_q[j]   <= n_q[j];
        end
        r_quo <= w_sum[QW:1];
    end

    assign w_sum = {1'b0, r_q[QW]} + (QW+1)'(1);
    assign o_quo = r_quo;

endmodule

`default_nettype wire
